>>> hw/rtl/wtv_pkg.sv
// ============================================================================
// Wavetable tone voice package
// Shared payload types, command and status types, constants and the CORDIC
// angle table for the wavetable tone voice.
// ============================================================================
package wtv_pkg;

    localparam int TABLE_ENTRIES_DEF = 200;
    localparam int CORDIC_STEPS      = 30;
    localparam int DIV_STEPS         = 48;
    localparam int STEP_W            = 6;
    localparam int CFG_INDEX_W       = 4;
    localparam int CFG_DATA_W        = 41;

    typedef struct packed {
        logic [39:0]        sample_time;
        logic signed [23:0] mix_in_left;
        logic signed [23:0] mix_in_right;
    } wtv_in_t;

    typedef struct packed {
        logic signed [23:0] mix_out_left;
        logic signed [23:0] mix_out_right;
        logic               voice_finished;
    } wtv_out_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP   = 4'd0,
        CFG_GAIN_LEFT    = 4'd1,
        CFG_GAIN_RIGHT   = 4'd2,
        CFG_START_TIME   = 4'd3,
        CFG_HOLD_LENGTH  = 4'd4,
        CFG_ATTACK_LEN   = 4'd5,
        CFG_RELEASE_LEN  = 4'd6,
        CFG_DISTORTION   = 4'd7
    } wtv_cfg_idx_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_INIT_LOAD,
        DP_ROT_STEP,
        DP_INIT_WR,
        DP_CAPTURE,
        DP_CHECK,
        DP_ENV_SETUP,
        DP_DIV_STEP,
        DP_ENV_DONE,
        DP_PHASE,
        DP_RD0,
        DP_RD1,
        DP_MUL1,
        DP_ASHIFT,
        DP_VNUM_LOAD,
        DP_VEC_STEP,
        DP_VDEN_LOAD,
        DP_DDIV_SETUP,
        DP_DIST_DONE,
        DP_GAIN_L,
        DP_ENV_L,
        DP_SUM_L,
        DP_GAIN_R,
        DP_ENV_R,
        DP_SUM_R,
        DP_ADVANCE,
        DP_DELIVER
    } wtv_op_t;

    typedef struct packed {
        wtv_op_t           op;
        logic [STEP_W-1:0] step;
    } wtv_cmd_t;

    typedef struct packed {
        logic init_last;
        logic live;
        logic dist_en;
    } wtv_status_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            unique case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                5'd24:   v = 32'h00000029;
                5'd25:   v = 32'h00000014;
                5'd26:   v = 32'h0000000A;
                5'd27:   v = 32'h00000005;
                5'd28:   v = 32'h00000003;
                5'd29:   v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

>>> hw/rtl/wtv_ctrl.sv
// ============================================================================
// Wavetable tone voice controller
// Sequences the table build after reset and the per-item steps of the
// datapath, and owns both handshakes.
// ============================================================================
module wtv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  wtv_pkg::wtv_status_t status,
    output wtv_pkg::wtv_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_INIT_LOAD, S_INIT_ROT, S_INIT_WR, S_IDLE, S_CHECK, S_BRANCH,
        S_ENV_SETUP, S_ENV_DIV, S_ENV_DONE, S_PHASE, S_RD0, S_RD1, S_MUL1,
        S_ASHIFT, S_VNUM_LOAD, S_VNUM, S_VDEN_LOAD, S_VDEN, S_DDIV_SETUP,
        S_DDIV, S_DIST_DONE, S_GAIN_L, S_ENV_L, S_SUM_L, S_GAIN_R, S_ENV_R,
        S_SUM_R, S_ADVANCE, S_DELIVER
    } state_t;

    localparam logic [wtv_pkg::STEP_W-1:0] CORDIC_LAST =
        wtv_pkg::STEP_W'(wtv_pkg::CORDIC_STEPS - 1);
    localparam logic [wtv_pkg::STEP_W-1:0] DIV_LAST =
        wtv_pkg::STEP_W'(wtv_pkg::DIV_STEPS - 1);

    state_t                     state_reg;
    logic [wtv_pkg::STEP_W-1:0] step_reg;
    logic                       m_valid_reg;
    logic                       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd.step = step_reg;
        unique case (state_reg)
            S_INIT_LOAD:  cmd.op = wtv_pkg::DP_INIT_LOAD;
            S_INIT_ROT:   cmd.op = wtv_pkg::DP_ROT_STEP;
            S_INIT_WR:    cmd.op = wtv_pkg::DP_INIT_WR;
            S_IDLE:       cmd.op = s_valid ? wtv_pkg::DP_CAPTURE : wtv_pkg::DP_NOP;
            S_CHECK:      cmd.op = wtv_pkg::DP_CHECK;
            S_BRANCH:     cmd.op = wtv_pkg::DP_NOP;
            S_ENV_SETUP:  cmd.op = wtv_pkg::DP_ENV_SETUP;
            S_ENV_DIV:    cmd.op = wtv_pkg::DP_DIV_STEP;
            S_ENV_DONE:   cmd.op = wtv_pkg::DP_ENV_DONE;
            S_PHASE:      cmd.op = wtv_pkg::DP_PHASE;
            S_RD0:        cmd.op = wtv_pkg::DP_RD0;
            S_RD1:        cmd.op = wtv_pkg::DP_RD1;
            S_MUL1:       cmd.op = wtv_pkg::DP_MUL1;
            S_ASHIFT:     cmd.op = wtv_pkg::DP_ASHIFT;
            S_VNUM_LOAD:  cmd.op = wtv_pkg::DP_VNUM_LOAD;
            S_VNUM:       cmd.op = wtv_pkg::DP_VEC_STEP;
            S_VDEN_LOAD:  cmd.op = wtv_pkg::DP_VDEN_LOAD;
            S_VDEN:       cmd.op = wtv_pkg::DP_VEC_STEP;
            S_DDIV_SETUP: cmd.op = wtv_pkg::DP_DDIV_SETUP;
            S_DDIV:       cmd.op = wtv_pkg::DP_DIV_STEP;
            S_DIST_DONE:  cmd.op = wtv_pkg::DP_DIST_DONE;
            S_GAIN_L:     cmd.op = wtv_pkg::DP_GAIN_L;
            S_ENV_L:      cmd.op = wtv_pkg::DP_ENV_L;
            S_SUM_L:      cmd.op = wtv_pkg::DP_SUM_L;
            S_GAIN_R:     cmd.op = wtv_pkg::DP_GAIN_R;
            S_ENV_R:      cmd.op = wtv_pkg::DP_ENV_R;
            S_SUM_R:      cmd.op = wtv_pkg::DP_SUM_R;
            S_ADVANCE:    cmd.op = wtv_pkg::DP_ADVANCE;
            S_DELIVER:    cmd.op = out_free ? wtv_pkg::DP_DELIVER : wtv_pkg::DP_NOP;
            default:      cmd.op = wtv_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT_LOAD;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_DELIVER && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= S_INIT_ROT;
                end
                S_INIT_ROT: begin
                    if (step_reg == CORDIC_LAST) begin
                        state_reg <= S_INIT_WR;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_INIT_WR:    state_reg <= status.init_last ? S_IDLE : S_INIT_LOAD;
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:      state_reg <= S_BRANCH;
                S_BRANCH:     state_reg <= status.live ? S_ENV_SETUP : S_DELIVER;
                S_ENV_SETUP: begin
                    step_reg  <= '0;
                    state_reg <= S_ENV_DIV;
                end
                S_ENV_DIV: begin
                    if (step_reg == DIV_LAST) begin
                        state_reg <= S_ENV_DONE;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_ENV_DONE:   state_reg <= S_PHASE;
                S_PHASE:      state_reg <= S_RD0;
                S_RD0:        state_reg <= S_RD1;
                S_RD1:        state_reg <= S_MUL1;
                S_MUL1:       state_reg <= S_ASHIFT;
                S_ASHIFT:     state_reg <= status.dist_en ? S_VNUM_LOAD : S_GAIN_L;
                S_VNUM_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= S_VNUM;
                end
                S_VNUM: begin
                    if (step_reg == CORDIC_LAST) begin
                        state_reg <= S_VDEN_LOAD;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_VDEN_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= S_VDEN;
                end
                S_VDEN: begin
                    if (step_reg == CORDIC_LAST) begin
                        state_reg <= S_DDIV_SETUP;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_DDIV_SETUP: begin
                    step_reg  <= '0;
                    state_reg <= S_DDIV;
                end
                S_DDIV: begin
                    if (step_reg == DIV_LAST) begin
                        state_reg <= S_DIST_DONE;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_DIST_DONE:  state_reg <= S_GAIN_L;
                S_GAIN_L:     state_reg <= S_ENV_L;
                S_ENV_L:      state_reg <= S_SUM_L;
                S_SUM_L:      state_reg <= S_GAIN_R;
                S_GAIN_R:     state_reg <= S_ENV_R;
                S_ENV_R:      state_reg <= S_SUM_R;
                S_SUM_R:      state_reg <= S_ADVANCE;
                S_ADVANCE:    state_reg <= S_DELIVER;
                S_DELIVER: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:      state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/wtv_datapath.sv
// ============================================================================
// Wavetable tone voice datapath
// Configuration registers, voice state, sine table memory, a shared CORDIC
// stage, a shared restoring divider and multipliers, driven by commands.
// ============================================================================
module wtv_datapath #(
    parameter int TABLE_ENTRIES = wtv_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wtv_pkg::wtv_cmd_t                   cmd,
    output wtv_pkg::wtv_status_t                status,
    input  wtv_pkg::wtv_in_t                    in_data,
    input  logic                                cfg_write,
    input  logic [wtv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wtv_pkg::CFG_DATA_W-1:0]      cfg_data,
    output wtv_pkg::wtv_out_t                   out_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [32:0] ANG_Q = 33'((64'd1 << 32) / TABLE_ENTRIES);
    localparam logic [IDX_W:0] ANG_R = (IDX_W + 1)'((64'd1 << 32) % TABLE_ENTRIES);
    localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] BOT_MAX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {ENV_ATTACK, ENV_RELEASE, ENV_FULL} env_mode_t;

    logic [31:0]        phase_step_reg;
    logic [15:0]        gain_left_reg;
    logic [15:0]        gain_right_reg;
    logic [23:0]        hold_reg;
    logic [23:0]        attack_reg;
    logic [23:0]        release_reg;
    logic [7:0]         dist_reg;

    logic [31:0]        phase_reg;
    logic signed [40:0] latched_reg;
    logic               dead_reg;
    logic               live_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [32:0]        ang_q_reg;
    logic [IDX_W-1:0]   ang_r_reg;

    logic signed [15:0] sine_mem [TABLE_ENTRIES + 1];
    logic signed [15:0] rdata_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic [39:0]        time_reg;
    logic signed [23:0] mix_l_reg;
    logic signed [23:0] mix_r_reg;
    logic signed [23:0] res_l_reg;
    logic signed [23:0] res_r_reg;

    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic signed [33:0] cz_reg;
    logic               neg_reg;
    logic signed [33:0] num_reg;

    logic [47:0]        dvd_reg;
    logic [31:0]        dvs_reg;
    logic [31:0]        rem_reg;
    logic [47:0]        quo_reg;

    logic [24:0]        e_reg;
    env_mode_t          env_mode_reg;
    logic [16:0]        env_reg;
    logic [IDX_W-1:0]   bot_reg;
    logic [15:0]        frac_reg;
    logic signed [34:0] acc_reg;
    logic signed [17:0] a_reg;
    logic signed [34:0] m1_reg;
    logic signed [52:0] m2_reg;

    wtv_pkg::wtv_out_t  out_reg;

    logic signed [35:0] shr_x;
    logic signed [35:0] shr_y;
    logic signed [33:0] atan_v;
    logic signed [33:0] z0;
    logic signed [35:0] y_round;
    logic signed [35:0] y_signed;
    logic signed [15:0] y_sat;
    logic [IDX_W:0]     r_sum;
    logic signed [42:0] s_ext;
    logic signed [42:0] limit;
    logic               dead_now;
    logic signed [40:0] lat_new;
    logic signed [42:0] e_full;
    logic [23:0]        att1;
    logic [23:0]        rel1;
    logic [32:0]        div_trial;
    logic               div_bit;
    logic [63:0]        p_full;
    logic [IDX_W-1:0]   bot_raw;
    logic [9:0]         k_v;
    logic signed [27:0] ak_prod;
    logic signed [33:0] den_v;
    logic [33:0]        mag_v;
    logic signed [17:0] q_s;
    logic signed [53:0] sum_v;
    logic signed [23:0] sum_sat;

    always_comb begin
        shr_x    = cx_reg >>> cmd.step;
        shr_y    = cy_reg >>> cmd.step;
        atan_v   = $signed({2'b00, wtv_pkg::atan_turn(cmd.step[4:0])});
        z0       = 34'($signed(ang_q_reg[31:0]));
        y_round  = (cy_reg + 36'sd16384) >>> 15;
        y_signed = neg_reg ? -y_round : y_round;
        if (y_signed > 36'sd32767) begin
            y_sat = 16'sh7FFF;
        end else if (y_signed < -36'sd32768) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = y_signed[15:0];
        end
        r_sum = {1'b0, ang_r_reg} + ANG_R;

        s_ext    = $signed({3'b000, time_reg});
        limit    = 43'(latched_reg) + $signed({19'b0, hold_reg})
                 + $signed({19'b0, release_reg});
        dead_now = dead_reg || (s_ext > limit);
        lat_new  = (latched_reg == -41'sd1) ? $signed({1'b0, time_reg}) : latched_reg;
        e_full   = s_ext - 43'(lat_new);
        att1     = (attack_reg == 24'd0) ? 24'd1 : attack_reg;
        rel1     = (release_reg == 24'd0) ? 24'd1 : release_reg;

        div_trial = {rem_reg, dvd_reg[47]};
        div_bit   = div_trial >= {1'b0, dvs_reg};

        p_full  = 64'(phase_reg) * 64'(TABLE_ENTRIES);
        bot_raw = p_full[32 +: IDX_W];

        k_v     = 10'd16 + {2'b00, dist_reg};
        ak_prod = a_reg * $signed(k_v);
        den_v   = (cz_reg <= 34'sd0) ? 34'sd1 : cz_reg;
        mag_v   = (num_reg < 34'sd0) ? 34'(-num_reg) : 34'(num_reg);
        q_s     = $signed({1'b0, quo_reg[16:0]});

        sum_v = ((54'(m2_reg) + 54'sd4194304) >>> 23)
              + ((cmd.op == wtv_pkg::DP_SUM_L) ? 54'(mix_l_reg) : 54'(mix_r_reg));
        if (sum_v > 54'sd8388607) begin
            sum_sat = 24'sh7FFFFF;
        end else if (sum_v < -54'sd8388608) begin
            sum_sat = -24'sh800000;
        end else begin
            sum_sat = sum_v[23:0];
        end

        rd_addr = (cmd.op == wtv_pkg::DP_RD1) ? bot_reg + 1'b1 : bot_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == wtv_pkg::DP_INIT_WR) begin
            sine_mem[idx_reg] <= y_sat;
        end
        rdata_reg <= sine_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            gain_left_reg  <= '0;
            gain_right_reg <= '0;
            hold_reg       <= '0;
            attack_reg     <= 24'd1000;
            release_reg    <= 24'd1000;
            dist_reg       <= '0;
            phase_reg      <= '0;
            latched_reg    <= -41'sd1;
            dead_reg       <= 1'b0;
            live_reg       <= 1'b0;
            idx_reg        <= '0;
            ang_q_reg      <= '0;
            ang_r_reg      <= '0;
        end else begin
            if (cfg_write) begin
                unique case (wtv_pkg::wtv_cfg_idx_t'(cfg_index))
                    wtv_pkg::CFG_PHASE_STEP:  phase_step_reg <= cfg_data[31:0];
                    wtv_pkg::CFG_GAIN_LEFT:   gain_left_reg  <= cfg_data[15:0];
                    wtv_pkg::CFG_GAIN_RIGHT:  gain_right_reg <= cfg_data[15:0];
                    wtv_pkg::CFG_START_TIME:  latched_reg    <= $signed(cfg_data);
                    wtv_pkg::CFG_HOLD_LENGTH: hold_reg       <= cfg_data[23:0];
                    wtv_pkg::CFG_ATTACK_LEN:  attack_reg     <= cfg_data[23:0];
                    wtv_pkg::CFG_RELEASE_LEN: release_reg    <= cfg_data[23:0];
                    wtv_pkg::CFG_DISTORTION:  dist_reg       <= cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (cmd.op)
                wtv_pkg::DP_INIT_WR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (r_sum >= N_EXT) begin
                        ang_r_reg <= IDX_W'(r_sum - N_EXT);
                        ang_q_reg <= ang_q_reg + ANG_Q + 33'd1;
                    end else begin
                        ang_r_reg <= IDX_W'(r_sum);
                        ang_q_reg <= ang_q_reg + ANG_Q;
                    end
                end
                wtv_pkg::DP_CHECK: begin
                    dead_reg <= dead_now;
                    live_reg <= !dead_now && (43'(lat_new) <= s_ext);
                    if (!dead_now) begin
                        latched_reg <= lat_new;
                    end
                end
                wtv_pkg::DP_ADVANCE: phase_reg <= phase_reg + phase_step_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            wtv_pkg::DP_INIT_LOAD: begin
                cx_reg <= 36'sd130406575;
                cy_reg <= '0;
                if (z0 > 34'sd1073741824) begin
                    cz_reg  <= z0 - 34'sd2147483648;
                    neg_reg <= 1'b1;
                end else if (z0 < -34'sd1073741824) begin
                    cz_reg  <= z0 + 34'sd2147483648;
                    neg_reg <= 1'b1;
                end else begin
                    cz_reg  <= z0;
                    neg_reg <= 1'b0;
                end
            end
            wtv_pkg::DP_ROT_STEP: begin
                if (cz_reg >= 34'sd0) begin
                    cx_reg <= cx_reg - shr_y;
                    cy_reg <= cy_reg + shr_x;
                    cz_reg <= cz_reg - atan_v;
                end else begin
                    cx_reg <= cx_reg + shr_y;
                    cy_reg <= cy_reg - shr_x;
                    cz_reg <= cz_reg + atan_v;
                end
            end
            wtv_pkg::DP_VEC_STEP: begin
                if (cy_reg >= 36'sd0) begin
                    cx_reg <= cx_reg + shr_y;
                    cy_reg <= cy_reg - shr_x;
                    cz_reg <= cz_reg + atan_v;
                end else begin
                    cx_reg <= cx_reg - shr_y;
                    cy_reg <= cy_reg + shr_x;
                    cz_reg <= cz_reg - atan_v;
                end
            end
            wtv_pkg::DP_CAPTURE: begin
                time_reg  <= in_data.sample_time;
                mix_l_reg <= in_data.mix_in_left;
                mix_r_reg <= in_data.mix_in_right;
                res_l_reg <= in_data.mix_in_left;
                res_r_reg <= in_data.mix_in_right;
            end
            wtv_pkg::DP_CHECK: e_reg <= e_full[24:0];
            wtv_pkg::DP_ENV_SETUP: begin
                rem_reg <= '0;
                quo_reg <= '0;
                if (e_reg < {1'b0, attack_reg}) begin
                    env_mode_reg <= ENV_ATTACK;
                    dvd_reg      <= {7'b0, e_reg, 16'b0};
                    dvs_reg      <= {8'b0, att1};
                end else if (e_reg >= {1'b0, hold_reg}) begin
                    env_mode_reg <= ENV_RELEASE;
                    dvd_reg      <= {7'b0, 25'(e_reg - {1'b0, hold_reg}), 16'b0};
                    dvs_reg      <= {8'b0, rel1};
                end else begin
                    env_mode_reg <= ENV_FULL;
                    dvd_reg      <= '0;
                    dvs_reg      <= 32'd1;
                end
            end
            wtv_pkg::DP_DIV_STEP: begin
                rem_reg <= div_bit ? 32'(div_trial - {1'b0, dvs_reg}) : div_trial[31:0];
                dvd_reg <= {dvd_reg[46:0], 1'b0};
                quo_reg <= {quo_reg[46:0], div_bit};
            end
            wtv_pkg::DP_ENV_DONE: begin
                unique case (env_mode_reg)
                    ENV_ATTACK:  env_reg <= (quo_reg >= 48'd65536) ? 17'd65536 : quo_reg[16:0];
                    ENV_RELEASE: env_reg <= (quo_reg >= 48'd65536) ? 17'd0
                                          : 17'(18'd65536 - {1'b0, quo_reg[16:0]});
                    default:     env_reg <= 17'd65536;
                endcase
            end
            wtv_pkg::DP_PHASE: begin
                bot_reg  <= (bot_raw > BOT_MAX) ? BOT_MAX : bot_raw;
                frac_reg <= p_full[31:16];
            end
            wtv_pkg::DP_RD1: begin
                acc_reg <= 35'(rdata_reg * $signed({1'b0, 17'(18'd65536 - {2'b0, frac_reg})}));
            end
            wtv_pkg::DP_MUL1: begin
                acc_reg <= acc_reg + 35'(rdata_reg * $signed({1'b0, frac_reg}))
                         + 35'sd32768;
            end
            wtv_pkg::DP_ASHIFT: a_reg <= 18'(acc_reg >>> 16);
            wtv_pkg::DP_VNUM_LOAD: begin
                cx_reg <= 36'sd536870912;
                cy_reg <= 36'(ak_prod) <<< 10;
                cz_reg <= '0;
            end
            wtv_pkg::DP_VDEN_LOAD: begin
                num_reg <= cz_reg;
                cx_reg  <= 36'sd536870912;
                cy_reg  <= $signed({1'b0, k_v, 25'b0});
                cz_reg  <= '0;
            end
            wtv_pkg::DP_DDIV_SETUP: begin
                rem_reg <= '0;
                quo_reg <= '0;
                dvd_reg <= {mag_v[32:0], 15'b0} + 48'(den_v[33:1]);
                dvs_reg <= den_v[31:0];
            end
            wtv_pkg::DP_DIST_DONE: a_reg <= (num_reg < 34'sd0) ? -q_s : q_s;
            wtv_pkg::DP_GAIN_L: m1_reg <= a_reg * $signed({1'b0, gain_left_reg});
            wtv_pkg::DP_GAIN_R: m1_reg <= a_reg * $signed({1'b0, gain_right_reg});
            wtv_pkg::DP_ENV_L,
            wtv_pkg::DP_ENV_R: m2_reg <= m1_reg * $signed({1'b0, env_reg});
            wtv_pkg::DP_SUM_L: res_l_reg <= sum_sat;
            wtv_pkg::DP_SUM_R: res_r_reg <= sum_sat;
            wtv_pkg::DP_DELIVER: begin
                out_reg.mix_out_left   <= res_l_reg;
                out_reg.mix_out_right  <= res_r_reg;
                out_reg.voice_finished <= dead_reg;
            end
            default: ;
        endcase
    end

    assign status.init_last = ({1'b0, idx_reg} == N_EXT);
    assign status.live      = live_reg;
    assign status.dist_en   = (dist_reg != 8'd0);
    assign out_data         = out_reg;

endmodule

>>> hw/rtl/wavetable_tone_voice_top.sv
// ============================================================================
// Wavetable tone voice
// One synthesiser voice: interpolated sine table, optional atan soft clip,
// attack/release envelope and stereo gains, added to the incoming mix.
//
//   Channel   Ports                              Carries
//   input     s_valid, s_ready, s_data           tick number and stereo mix
//   result    m_valid, m_ready, m_data           saturated mix, finished flag
//   config    cfg_valid, cfg_ready, cfg_index,   register writes, always ready
//             cfg_data
//
// A live item runs the 48-step envelope division, the interpolated table
// read, the gains and the sums; with the soft clip on it also runs two
// 30-step CORDIC passes and a second 48-step division before the gains.
// Dead or not yet started items skip all of this and go straight to delivery.
// After reset the sine table is built, TABLE_ENTRIES + 1 entries, while
// no item is accepted. A result waits in its output register if m_ready is
// low; the next item is then worked on and held back before delivery.
// ============================================================================
module wavetable_tone_voice_top #(
    parameter int TABLE_ENTRIES = wtv_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  wtv_pkg::wtv_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output wtv_pkg::wtv_out_t               m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wtv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wtv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    wtv_pkg::wtv_cmd_t    cmd;
    wtv_pkg::wtv_status_t status;

    assign cfg_ready = 1'b1;

    wtv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wtv_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_data),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_data)
    );

endmodule

>>> sim/wtv_checker.sv
// ============================================================================
// Wavetable tone voice checker
// Watches the configuration, input and result channels of the voice. It keeps
// its own copy of the registers and voice state, predicts each result and
// compares it field by field with what the block delivers.
// ============================================================================
module wtv_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  wtv_pkg::wtv_in_t                s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  wtv_pkg::wtv_out_t               m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [wtv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wtv_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              checked
);

    localparam int  ENTRIES = 200;
    localparam longint MIX_HI = 8388607;
    localparam longint MIX_LO = -8388608;

    longint turns [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    logic [31:0] phase_step;
    logic [15:0] gain_l, gain_r;
    logic [23:0] hold_len, attack_len, release_len;
    logic [7:0]  drive;
    logic [31:0] phase;
    longint      start_tick;
    logic        dead;
    longint      sine [ENTRIES+1];
    wtv_pkg::wtv_out_t mix_queue [$];

    function automatic longint rotate_sine(longint z);
        longint x, y, nx;
        logic   neg;
        x   = 130406575;
        y   = 0;
        neg = 1'b0;
        if (z > 64'sh40000000) begin
            z = z - 64'sh80000000;
            neg = 1'b1;
        end else if (z < -64'sh40000000) begin
            z = z + 64'sh80000000;
            neg = 1'b1;
        end
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - turns[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + turns[i];
            end
            x = nx;
        end
        y = (y + 16384) >>> 15;
        return neg ? -y : y;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, nx;
        z = 0;
        for (int i = 0; i < 30; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + turns[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - turns[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint clip_mix(longint v);
        if (v > MIX_HI) return MIX_HI;
        if (v < MIX_LO) return MIX_LO;
        return v;
    endfunction

    function automatic wtv_pkg::wtv_out_t mix_voice(wtv_pkg::wtv_in_t it);
        wtv_pkg::wtv_out_t r;
        longint     t, ol, orr, a, env, k, num, den, mag, q, f;
        longint     att, rel;
        logic [63:0] e, p, bot;
        t   = longint'({24'd0, it.sample_time});
        ol  = longint'(it.mix_in_left);
        orr = longint'(it.mix_in_right);
        if (dead || t > start_tick + longint'(hold_len) + longint'(release_len)) begin
            dead = 1'b1;
        end else begin
            if (start_tick == -1) start_tick = t;
            if (start_tick <= t) begin
                e   = t - start_tick;
                att = (attack_len == 0) ? 1 : longint'(attack_len);
                rel = (release_len == 0) ? 1 : longint'(release_len);
                env = 65536;
                if (e < attack_len) begin
                    env = (e * 65536) / att;
                end else if (e >= hold_len) begin
                    env = 65536 - longint'(((e - hold_len) * 65536) / rel);
                end
                if (env < 0) env = 0;
                if (env > 65536) env = 65536;
                p   = 64'(phase) * ENTRIES;
                bot = p >> 32;
                f   = longint'(p[31:16]);
                if (bot > ENTRIES - 1) bot = ENTRIES - 1;
                a = (sine[bot] * (65536 - f) + sine[bot+1] * f + 32768) >>> 16;
                if (drive != 0) begin
                    k   = 16 + longint'(drive);
                    num = vector_angle(a * k * 1024, 64'sd1 << 29);
                    den = vector_angle(k * (64'sd1 << 25), 64'sd1 << 29);
                    mag = (num < 0) ? -num : num;
                    if (den <= 0) den = 1;
                    q = (mag * 32768 + den / 2) / den;
                    a = (num < 0) ? -q : q;
                end
                ol  = clip_mix(ol + ((a * longint'(gain_l) * env + 4194304) >>> 23));
                orr = clip_mix(orr + ((a * longint'(gain_r) * env + 4194304) >>> 23));
                phase = phase + phase_step;
            end
        end
        r.mix_out_left   = ol[23:0];
        r.mix_out_right  = orr[23:0];
        r.voice_finished = dead;
        return r;
    endfunction

    initial begin
        longint ang;
        for (int i = 0; i <= ENTRIES; i++) begin
            ang = ((longint'(i) << 32) / ENTRIES) & 64'hFFFFFFFF;
            if (ang >= 64'sh80000000) ang = ang - 64'sh100000000;
            sine[i] = rotate_sine(ang);
            if (sine[i] > 32767) sine[i] = 32767;
            if (sine[i] < -32768) sine[i] = -32768;
        end
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    always @(posedge aclk) begin
        wtv_pkg::wtv_out_t want;
        if (!aresetn) begin
            phase_step  = '0;
            gain_l      = '0;
            gain_r      = '0;
            hold_len    = '0;
            attack_len  = 24'd1000;
            release_len = 24'd1000;
            drive       = '0;
            phase       = '0;
            start_tick  = -1;
            dead        = 1'b0;
            mix_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (wtv_pkg::wtv_cfg_idx_t'(cfg_index))
                    wtv_pkg::CFG_PHASE_STEP:  phase_step  = cfg_data[31:0];
                    wtv_pkg::CFG_GAIN_LEFT:   gain_l      = cfg_data[15:0];
                    wtv_pkg::CFG_GAIN_RIGHT:  gain_r      = cfg_data[15:0];
                    wtv_pkg::CFG_START_TIME:  start_tick  = longint'($signed(cfg_data));
                    wtv_pkg::CFG_HOLD_LENGTH: hold_len    = cfg_data[23:0];
                    wtv_pkg::CFG_ATTACK_LEN:  attack_len  = cfg_data[23:0];
                    wtv_pkg::CFG_RELEASE_LEN: release_len = cfg_data[23:0];
                    wtv_pkg::CFG_DISTORTION:  drive       = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (mix_queue.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_data);
                    fail_count = fail_count + 1;
                end else begin
                    want = mix_queue.pop_front();
                    checked = checked + 1;
                    if (want.mix_out_left !== m_data.mix_out_left) begin
                        $display("%0t: mix_out_left expected %0d actual %0d", $time,
                                 want.mix_out_left, m_data.mix_out_left);
                        fail_count = fail_count + 1;
                    end
                    if (want.mix_out_right !== m_data.mix_out_right) begin
                        $display("%0t: mix_out_right expected %0d actual %0d", $time,
                                 want.mix_out_right, m_data.mix_out_right);
                        fail_count = fail_count + 1;
                    end
                    if (want.voice_finished !== m_data.voice_finished) begin
                        $display("%0t: voice_finished expected %0b actual %0b", $time,
                                 want.voice_finished, m_data.voice_finished);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) mix_queue.insert(mix_queue.size(), mix_voice(s_data));
        end
        pending = mix_queue.size();
    end

endmodule

>>> sim/tb.sv
// ============================================================================
// Wavetable tone voice testbench
// Drives register settings and runs of sample ticks into the voice, with
// random idling on both channels, and leaves prediction and comparison to
// the checker beside the block.
// ============================================================================
module tb;

    localparam longint MAX_TICK = 64'hFF_FFFF_FFFF;
    localparam int     WATCHDOG = 40000;

    logic     aclk, aresetn;
    logic     s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    wtv_pkg::wtv_in_t  s_data;
    wtv_pkg::wtv_out_t m_data;
    logic [wtv_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wtv_pkg::CFG_DATA_W-1:0]  cfg_data;
    int       fail_count, pending, checked;
    int       items, settings, quiet_cnt, stall_cnt;
    logic     quiet;

    wavetable_tone_voice_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    wtv_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (stall_cnt > 0) begin
            m_ready = 1'b0;
            stall_cnt = stall_cnt - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_ready = 1'b0;
            stall_cnt = $urandom_range(0, 6);
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cnt = 0;
        end else begin
            quiet_cnt = quiet_cnt + 1;
        end
        if (quiet_cnt >= WATCHDOG) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input wtv_pkg::wtv_cfg_idx_t idx, input longint value,
                             input int width);
        logic [wtv_pkg::CFG_DATA_W-1:0] d, mask;
        d    = wtv_pkg::CFG_DATA_W'({$urandom, $urandom});
        mask = (width >= wtv_pkg::CFG_DATA_W) ? '1 : ((41'd1 << width) - 1);
        d    = (d & ~mask) | (wtv_pkg::CFG_DATA_W'(value) & mask);
        cfg_index = idx;
        cfg_data  = d;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_spare;
        cfg_index = wtv_pkg::CFG_INDEX_W'($urandom_range(8, 15));
        cfg_data  = wtv_pkg::CFG_DATA_W'({$urandom, $urandom});
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_tick(input longint t);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge aclk);
        end
        s_data.sample_time  = t[39:0];
        s_data.mix_in_left  = 24'($urandom);
        s_data.mix_in_right = 24'($urandom);
        if ($urandom_range(0, 7) == 0) s_data.mix_in_left  = 24'h7FFFFF;
        if ($urandom_range(0, 7) == 0) s_data.mix_in_right = 24'h800000;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items = items + 1;
    endtask

    task automatic settle;
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        settings = settings + 1;
    endtask

    task automatic run_phase;
        longint h, r, a, base, lim, t, step, span;
        int     n;
        logic   latch_first;
        settle();
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 300);
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 300);
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24'hFFFFFF) : $urandom_range(1, 300);
        case ($urandom_range(0, 3))
            0:       write_reg(wtv_pkg::CFG_PHASE_STEP, 64'h80000000, 32);
            1:       write_reg(wtv_pkg::CFG_PHASE_STEP, $urandom_range(0, 3), 32);
            default: write_reg(wtv_pkg::CFG_PHASE_STEP, $urandom, 32);
        endcase
        write_reg(wtv_pkg::CFG_GAIN_LEFT,
                  ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(0, 65535), 16);
        write_reg(wtv_pkg::CFG_GAIN_RIGHT,
                  ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 32768), 16);
        write_reg(wtv_pkg::CFG_HOLD_LENGTH, h, 24);
        write_reg(wtv_pkg::CFG_ATTACK_LEN,  a, 24);
        write_reg(wtv_pkg::CFG_RELEASE_LEN, r, 24);
        write_reg(wtv_pkg::CFG_DISTORTION,
                  ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 255), 8);
        if ($urandom_range(0, 3) == 0) write_spare();
        latch_first = ($urandom_range(0, 4) == 0);
        if (latch_first) begin
            write_reg(wtv_pkg::CFG_START_TIME, -1, 41);
            base = $urandom_range(0, int'(h + r - 1));
        end else begin
            base = {$urandom, $urandom} & MAX_TICK;
            if ($urandom_range(0, 3) == 0) base = $urandom_range(0, 500);
            write_reg(wtv_pkg::CFG_START_TIME, base, 41);
        end
        lim  = base + h + r;
        span = (h + r) / 8 + 1;
        t    = latch_first ? base : ((base > 5) ? base - $urandom_range(0, 5) : base);
        n    = $urandom_range(30, 70);
        if (latch_first) begin
            send_tick(base);
            n = n - 1;
        end
        while (n > 0 && t <= lim && t <= MAX_TICK) begin
            if (base > 0 && $urandom_range(0, 9) == 0) begin
                send_tick({$urandom, $urandom} % base);
            end else begin
                send_tick(t);
                step = ($urandom_range(0, 7) == 0) ? {$urandom} % span : $urandom_range(0, 3);
                t = t + step;
            end
            n = n - 1;
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        items     = 0;
        settings  = 0;
        quiet_cnt = 0;
        stall_cnt = 0;
        quiet     = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings, start latched by the first tick, then extremes.
        write_reg(wtv_pkg::CFG_PHASE_STEP, 64'h80000000, 32);
        write_reg(wtv_pkg::CFG_GAIN_LEFT, 32768, 16);
        write_reg(wtv_pkg::CFG_GAIN_RIGHT, 0, 16);
        write_reg(wtv_pkg::CFG_HOLD_LENGTH, 50, 24);
        write_reg(wtv_pkg::CFG_ATTACK_LEN, 10, 24);
        write_reg(wtv_pkg::CFG_RELEASE_LEN, 20, 24);
        send_tick(5);
        send_tick(6);
        send_tick(7);
        send_tick(2);
        send_tick(15);
        send_tick(30);
        send_tick(50);
        send_tick(60);
        send_tick(70);
        settle();
        write_reg(wtv_pkg::CFG_DISTORTION, 255, 8);
        write_reg(wtv_pkg::CFG_GAIN_LEFT, 65535, 16);
        write_reg(wtv_pkg::CFG_GAIN_RIGHT, 32768, 16);
        write_reg(wtv_pkg::CFG_ATTACK_LEN, 0, 24);
        write_reg(wtv_pkg::CFG_RELEASE_LEN, 0, 24);
        write_reg(wtv_pkg::CFG_HOLD_LENGTH, 100, 24);
        write_reg(wtv_pkg::CFG_START_TIME, MAX_TICK - 5, 41);
        write_spare();
        send_tick(0);
        for (longint t = MAX_TICK - 5; t <= MAX_TICK; t++) send_tick(t);
        settle();
        write_reg(wtv_pkg::CFG_DISTORTION, 1, 8);
        write_reg(wtv_pkg::CFG_HOLD_LENGTH, 24'hFFFFFF, 24);
        write_reg(wtv_pkg::CFG_ATTACK_LEN, 24'hFFFFFF, 24);
        write_reg(wtv_pkg::CFG_RELEASE_LEN, 24'hFFFFFF, 24);
        write_reg(wtv_pkg::CFG_START_TIME, 0, 41);
        write_reg(wtv_pkg::CFG_PHASE_STEP, 0, 32);
        send_tick(0);
        send_tick(24'hFFFFFF);
        send_tick(25'h1FFFFFE);

        while (items < 1560) run_phase();

        // Last part without idling: the voice ends and stays ended.
        settle();
        quiet = 1'b1;
        write_reg(wtv_pkg::CFG_START_TIME, 0, 41);
        write_reg(wtv_pkg::CFG_HOLD_LENGTH, 0, 24);
        write_reg(wtv_pkg::CFG_RELEASE_LEN, 1, 24);
        write_reg(wtv_pkg::CFG_ATTACK_LEN, 1, 24);
        send_tick(1);
        send_tick(5);
        repeat (30) send_tick({$urandom, $urandom} & MAX_TICK);
        settle();
        write_reg(wtv_pkg::CFG_START_TIME, 10, 41);
        repeat (30) send_tick($urandom_range(0, 40));
        send_tick(MAX_TICK);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(posedge aclk);

        $display("Sent %0d sample ticks over %0d register settings; %0d results checked.",
                 items, settings, checked);
        $display("Covered attack, hold and release, soft clip, start latch and ended voice.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/wtv_pkg.sv
hw/rtl/wtv_ctrl.sv
hw/rtl/wtv_datapath.sv
hw/rtl/wavetable_tone_voice_top.sv
sim/wtv_checker.sv
sim/tb.sv
